FILE: design/hsl2rgb_pkg.sv
// hsl2rgb_pkg: constants, types and hue ramp helpers for the hsl to rgb pixel pipeline
// no dependencies; used by design/hsl_to_rgb_pixel.sv
package hsl2rgb_pkg;

   localparam int SCALE      = 255;
   localparam int THIRD      = SCALE / 3;              // 85
   localparam int TWO_THIRDS = 2 * THIRD;              // 170
   localparam int RISE_LAST  = (SCALE - 1) / 6;        // last hue on the rising slope
   localparam int HIGH_LAST  = (SCALE - 1) / 2;        // last hue on the upper level
   localparam int FALL_LAST  = (2 * SCALE - 1) / 3;    // last hue on the falling slope
   localparam int DIV_CONST  = SCALE * SCALE;          // 65025
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP      = int'((64'd1 << RECIP_SHIFT) / DIV_CONST);  // 66051, floor
   localparam int NUM_STAGES = 6;

   localparam int CH_W   = 8;
   localparam int LVL_W  = 17;   // levels hi and lo, up to 255*255
   localparam int NUM_W  = 24;   // channel numerator, up to 255^3
   localparam int COEF_W = 8;    // slope factor, at most 252
   localparam int RECIP_W = 17;

   typedef enum logic [1:0] {
      SEL_LO    = 2'd0,
      SEL_HI    = 2'd1,
      SEL_SLOPE = 2'd2
   } ramp_sel_type;

   typedef struct packed {
      ramp_sel_type        sel;
      logic [COEF_W-1:0]   k;
   } ramp_coef_type;

   // hue plus one third, wrapped; a result of exactly 255 is kept
   function automatic logic [CH_W-1:0] hue_plus_third(input logic [CH_W-1:0] h);
      logic [CH_W:0] sum;
      begin
         sum = {1'b0, h} + (CH_W+1)'(THIRD);
         if (sum > (CH_W+1)'(SCALE))
            hue_plus_third = CH_W'(sum - (CH_W+1)'(SCALE));
         else
            hue_plus_third = sum[CH_W-1:0];
      end
   endfunction

   function automatic logic [CH_W-1:0] hue_minus_third(input logic [CH_W-1:0] h);
      begin
         if (h < CH_W'(THIRD))
            hue_minus_third = h + CH_W'(TWO_THIRDS);
         else
            hue_minus_third = h - CH_W'(THIRD);
      end
   endfunction

   // segment of the piecewise ramp and the slope factor for it
   function automatic ramp_coef_type ramp_coef(input logic [CH_W-1:0] h);
      ramp_coef_type c;
      logic [CH_W+1:0] six_h;
      logic [CH_W+1:0] six_fall;
      begin
         six_h    = ({2'b00, h} << 2) + ({2'b00, h} << 1);
         six_fall = ((CH_W+2)'(TWO_THIRDS) - {2'b00, h}) * (CH_W+2)'(6);
         c.sel = SEL_LO;
         c.k   = '0;
         if (h <= CH_W'(RISE_LAST)) begin
            c.sel = SEL_SLOPE;
            c.k   = six_h[COEF_W-1:0];
         end else if (h <= CH_W'(HIGH_LAST)) begin
            c.sel = SEL_HI;
         end else if (h <= CH_W'(FALL_LAST)) begin
            c.sel = SEL_SLOPE;
            c.k   = six_fall[COEF_W-1:0];
         end
         ramp_coef = c;
      end
   endfunction

endpackage

FILE: design/hsl_to_rgb_pixel.sv
// hsl_to_rgb_pixel: six-stage pipeline turning 8-bit hsl pixels into 8-bit rgb
// depends on design/hsl2rgb_pkg.sv
//
// Use:
//   req_*  stream of hsl words, tdata = {lightness, saturation, hue}, hue lowest.
//   rsp_*  stream of rgb words, tdata = {third, green, first}, first lowest.
//   csr_*  one-bit write of swap_red_blue; csr_ready is always high. Write it only
//          while the pipeline is empty.
//   rsp_tvalid rises when an accepted word reaches the sixth stage register. With
//   no stall on rsp_, one word enters and one leaves every cycle; the rate is
//   set by the pipeline of multipliers (l*s, slope times level gap, reciprocal
//   of 255^2).
//   Every stage has its own valid bit and load enable, so bubbles close up:
//   when the receiver stalls, words keep entering until all six stages hold
//   a word, and only then does req_tready drop. Nothing is lost or repeated.
//   Reset clears all valid bits and swap_red_blue; the pipeline starts empty.
module hsl_to_rgb_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // hue [7:0], saturation [15:8], lightness [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // first_channel [7:0], green_channel [15:8],
                                    // third_channel [23:16]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // swap_red_blue
);

   localparam int NS   = hsl2rgb_pkg::NUM_STAGES;
   localparam int CW   = hsl2rgb_pkg::CH_W;
   localparam int LW   = hsl2rgb_pkg::LVL_W;
   localparam int NW   = hsl2rgb_pkg::NUM_W;
   localparam int KW   = hsl2rgb_pkg::COEF_W;
   localparam int RW   = hsl2rgb_pkg::RECIP_W;
   localparam int PW   = NW + RW;

   // channel order inside the pipeline: 0 red, 1 green, 2 blue
   localparam int RED = 0;
   localparam int GRN = 1;
   localparam int BLU = 2;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;
   logic          swap_ff;

   // stage 1: inputs and l*s
   logic [CW-1:0]   hue1_ff, sat1_ff, lit1_ff;
   logic [2*CW-1:0] ls1_ff;

   // stage 2: levels and ramp segments
   logic [LW-1:0]   hi2_in, lo2_in, hi2_ff, lo2_ff, d2_ff;
   logic [CW-1:0]   lit255_2;
   hsl2rgb_pkg::ramp_coef_type coef2_in [3];
   hsl2rgb_pkg::ramp_coef_type coef2_ff [3];

   // stage 3: slope products and scaled levels
   logic [NW-1:0]   prod3_in [3];
   logic [NW-1:0]   prod3_ff [3];
   logic [NW-1:0]   lo255_3_ff, hi255_3_ff;
   logic [NW:0]     lo255_3_in, hi255_3_in;
   hsl2rgb_pkg::ramp_sel_type sel3_ff [3];

   // stage 4: channel numerators
   logic [NW-1:0]   num4_in [3];
   logic [NW-1:0]   num4_ff [3];

   // stage 5: reciprocal estimate of num / 255^2
   logic [PW-1:0]   qm5_in [3];
   logic [CW-1:0]   q5_ff [3];
   logic [NW-1:0]   num5_ff [3];

   // stage 6: corrected quotient, output register
   logic [NW-1:0]   qmul6 [3];
   logic [NW-1:0]   rem6 [3];
   logic [CW-1:0]   q6_in [3];
   logic [CW-1:0]   q6_ff [3];

   assign lit255_2 = lit1_ff;

   // load enables: a stage loads when it is empty or the next one moves on
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[NS-1];
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         swap_ff <= 1'b0;
      end else begin
         if (csr_valid)
            swap_ff <= csr_data;
         if (en[0])
            vld_ff[0] <= req_tvalid;
         for (int i = 1; i < NS; i++) begin
            if (en[i])
               vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // ---- stage 1
   always_ff @(posedge clock) begin
      if (en[0]) begin
         hue1_ff <= req_tdata[7:0];
         sat1_ff <= req_tdata[15:8];
         lit1_ff <= req_tdata[23:16];
         ls1_ff  <= req_tdata[23:16] * req_tdata[15:8];
      end
   end

   // ---- stage 2
   always_comb begin
      logic [LW-1:0] l255;
      logic [LW-1:0] s255;
      logic [LW-1:0] l510;
      l255 = ({{(LW-CW){1'b0}}, lit255_2} << CW) - LW'(lit255_2);
      s255 = ({{(LW-CW){1'b0}}, sat1_ff} << CW) - LW'(sat1_ff);
      l510 = l255 << 1;
      if (lit1_ff <= CW'(hsl2rgb_pkg::HIGH_LAST))
         hi2_in = l255 + LW'(ls1_ff);
      else
         hi2_in = l255 + s255 - LW'(ls1_ff);
      lo2_in = l510 - hi2_in;
      coef2_in[RED] = hsl2rgb_pkg::ramp_coef(hsl2rgb_pkg::hue_plus_third(hue1_ff));
      coef2_in[GRN] = hsl2rgb_pkg::ramp_coef(hue1_ff);
      coef2_in[BLU] = hsl2rgb_pkg::ramp_coef(hsl2rgb_pkg::hue_minus_third(hue1_ff));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hi2_ff   <= hi2_in;
         lo2_ff   <= lo2_in;
         d2_ff    <= hi2_in - lo2_in;
         coef2_ff <= coef2_in;
      end
   end

   // ---- stage 3
   always_comb begin
      lo255_3_in = ({lo2_ff, {CW{1'b0}}} - (NW+1)'(lo2_ff));
      hi255_3_in = ({hi2_ff, {CW{1'b0}}} - (NW+1)'(hi2_ff));
      for (int c = 0; c < 3; c++) begin
         prod3_in[c] = NW'(d2_ff) * NW'(coef2_ff[c].k);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         lo255_3_ff <= lo255_3_in[NW-1:0];
         hi255_3_ff <= hi255_3_in[NW-1:0];
         prod3_ff   <= prod3_in;
         for (int c = 0; c < 3; c++) begin
            sel3_ff[c] <= coef2_ff[c].sel;
         end
      end
   end

   // ---- stage 4
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (sel3_ff[c])
            hsl2rgb_pkg::SEL_HI:    num4_in[c] = hi255_3_ff;
            hsl2rgb_pkg::SEL_SLOPE: num4_in[c] = lo255_3_ff + prod3_ff[c];
            hsl2rgb_pkg::SEL_LO:    num4_in[c] = lo255_3_ff;
            default:                num4_in[c] = lo255_3_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[3])
         num4_ff <= num4_in;
   end

   // ---- stage 5: floor estimate, low by one when num sits at or just above a multiple of 255^2
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qm5_in[c] = num4_ff[c] * RW'(hsl2rgb_pkg::RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         num5_ff <= num4_ff;
         for (int c = 0; c < 3; c++) begin
            q5_ff[c] <= qm5_in[c][hsl2rgb_pkg::RECIP_SHIFT +: CW];
         end
      end
   end

   // ---- stage 6: remainder check, q0*65025 = q0*2^16 - q0*2^9 + q0
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qmul6[c] = ({{(NW-CW){1'b0}}, q5_ff[c]} << 16)
                  - ({{(NW-CW){1'b0}}, q5_ff[c]} << 9)
                  + NW'(q5_ff[c]);
         rem6[c]  = num5_ff[c] - qmul6[c];
         if (rem6[c] >= NW'(hsl2rgb_pkg::DIV_CONST))
            q6_in[c] = q5_ff[c] + CW'(1);
         else
            q6_in[c] = q5_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[5])
         q6_ff <= q6_in;
   end

   assign rsp_tdata = swap_ff ? {q6_ff[RED], q6_ff[GRN], q6_ff[BLU]}
                              : {q6_ff[BLU], q6_ff[GRN], q6_ff[RED]};

   // ---- checks
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&vld_ff))
      else $error("input blocked while a stage is empty");

   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted word did not reach the first stage");

   a_levels_ordered: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (lo2_ff <= hi2_ff))
      else $error("lower level above upper level");

   a_recip_close: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (rem6[0] < NW'(2 * hsl2rgb_pkg::DIV_CONST))
                 && (rem6[1] < NW'(2 * hsl2rgb_pkg::DIV_CONST))
                 && (rem6[2] < NW'(2 * hsl2rgb_pkg::DIV_CONST)))
      else $error("reciprocal estimate off by more than one");

endmodule

FILE: tb/hsl_to_rgb_checker.sv
// hsl_to_rgb_checker: watches the hsl, rgb and register channels of the pixel pipeline,
// predicts every rgb word in exact integer arithmetic and compares it field by field
// stand-alone; instantiated by tb/tb_hsl_to_rgb_pixel.sv
`timescale 1ns / 100ps

module hsl_to_rgb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // hue [7:0], saturation [15:8], lightness [23:16]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // first_channel [7:0], green_channel [15:8],
                                    // third_channel [23:16]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,    // swap_red_blue
   output int          error_count,
   output int          pending_words,
   output int          words_checked
);

   localparam int BYTE_SCALE = 255;
   localparam int HUE_THIRD  = 85;
   localparam int HUE_TWO_THIRDS = 170;

   typedef struct packed {
      logic [7:0] third_channel;
      logic [7:0] green_channel;
      logic [7:0] first_channel;
   } rgb_word_type;

   rgb_word_type expected_rgb_q[$];
   logic      order_swapped;
   int        failures;
   int        checked;

   // channel numerator over 255^3 for a hue numerator over 255
   function automatic int hue_ramp(input int lo, input int hi, input int hue);
      int h;
      h = hue;
      if (h < 0)
         h += BYTE_SCALE;
      if (h > BYTE_SCALE)
         h -= BYTE_SCALE;
      if (6 * h < BYTE_SCALE)
         return lo * BYTE_SCALE + (hi - lo) * 6 * h;
      if (2 * h < BYTE_SCALE)
         return hi * BYTE_SCALE;
      if (3 * h < 2 * BYTE_SCALE)
         return lo * BYTE_SCALE + (hi - lo) * (HUE_TWO_THIRDS - h) * 6;
      return lo * BYTE_SCALE;
   endfunction

   function automatic logic [7:0] channel_byte(input int num);
      int v;
      v = num / (BYTE_SCALE * BYTE_SCALE);
      if (v < 0)
         v = 0;
      if (v > BYTE_SCALE)
         v = BYTE_SCALE;
      return v[7:0];
   endfunction

   function automatic rgb_word_type hsl_to_rgb_word(input logic [7:0] hue,
                                                    input logic [7:0] sat,
                                                    input logic [7:0] light,
                                                    input logic       swapped);
      rgb_word_type w;
      logic [7:0] red, green, blue;
      int         h, s, l, hi, lo;
      h = hue;
      s = sat;
      l = light;
      if (s == 0) begin
         red   = light;
         green = light;
         blue  = light;
      end else begin
         // level choice: lightness up to 127 counts as below one half
         if (2 * l < BYTE_SCALE)
            hi = l * (BYTE_SCALE + s);
         else
            hi = BYTE_SCALE * l + BYTE_SCALE * s - s * l;
         lo = 2 * BYTE_SCALE * l - hi;
         red   = channel_byte(hue_ramp(lo, hi, h + HUE_THIRD));
         green = channel_byte(hue_ramp(lo, hi, h));
         blue  = channel_byte(hue_ramp(lo, hi, h - HUE_THIRD));
      end
      w.first_channel = swapped ? blue : red;
      w.green_channel = green;
      w.third_channel = swapped ? red : blue;
      return w;
   endfunction

   task automatic compare_channel(input string name, input logic [7:0] exp_val,
                                  input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rgb_word_type exp_word;
      rgb_word_type act_word;
      if (reset) begin
         order_swapped = 1'b0;
         expected_rgb_q.delete();
      end else begin
         // results first, so a stray word is never matched to one entering now
         if (rsp_tvalid && rsp_tready) begin
            act_word = rsp_tdata;
            if (expected_rgb_q.size() == 0) begin
               $display("%0t: unexpected rgb word, expected none got %h", $time, rsp_tdata);
               failures++;
            end else begin
               exp_word = expected_rgb_q.pop_front();
               compare_channel("first_channel", exp_word.first_channel,
                               act_word.first_channel);
               compare_channel("green_channel", exp_word.green_channel,
                               act_word.green_channel);
               compare_channel("third_channel", exp_word.third_channel,
                               act_word.third_channel);
               checked++;
            end
         end
         if (req_tvalid && req_tready)
            expected_rgb_q.push_back(hsl_to_rgb_word(req_tdata[7:0], req_tdata[15:8],
                                                     req_tdata[23:16], order_swapped));
         if (csr_valid && csr_ready)
            order_swapped = csr_data;
      end
      error_count   <= failures;
      pending_words <= expected_rgb_q.size();
      words_checked <= checked;
   end

   initial begin
      failures      = 0;
      checked       = 0;
      order_swapped = 1'b0;
      error_count   = 0;
      pending_words = 0;
      words_checked = 0;
   end

endmodule

FILE: tb/tb_hsl_to_rgb_pixel.sv
// tb_hsl_to_rgb_pixel: stimulus for the hsl to rgb pipeline: directed corner pixels, then
// random pixels under three idle mixes and a long receiver hold-off, both channel orders
// depends on design/hsl2rgb_pkg.sv, design/hsl_to_rgb_pixel.sv, tb/hsl_to_rgb_checker.sv
`timescale 1ns / 100ps

module tb_hsl_to_rgb_pixel;

   localparam int RANDOM_PER_PHASE = 300;
   localparam int HOLD_OFF_CYCLES  = 60;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int TAIL_CYCLES      = 12;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   int   error_count;
   int   pending_words;
   int   words_checked;
   int   sender_idle_pct   = 0;
   int   receiver_idle_pct = 0;
   int   cycle_count       = 0;
   logic hold_off_req      = 1'b0;
   logic hold_off_seen     = 1'b0;
   int   hold_left         = 0;

   always #5 clock = ~clock;

   hsl_to_rgb_pixel dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   hsl_to_rgb_checker pixel_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_words (pending_words),
      .words_checked (words_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_words);
         $display("FAIL hsl_to_rgb_pixel");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off whenever the request flag toggles
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req != hold_off_seen) begin
            hold_off_seen = hold_off_req;
            hold_left     = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                             input logic [7:0] light);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {light, sat, hue};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (pending_words != 0);
   endtask

   task automatic write_swap(input logic swap);
      csr_valid <= 1'b1;
      csr_data  <= swap;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_pixels(input int count);
      logic [7:0] sat;
      logic [7:0] light;
      repeat (count) begin
         // gray pixels, extreme lightness and the 127/128 level boundary now and then
         sat   = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(255));
         case ($urandom_range(19))
            0:       light = 8'd0;
            1:       light = 8'd255;
            2:       light = 8'($urandom_range(128, 127));
            default: light = 8'($urandom_range(255));
         endcase
         send_pixel(8'($urandom_range(255)), sat, light);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 30;
      receiver_idle_pct = 69;
      write_swap(1'b1);
      // corners: extremes, gray, level boundary, hue segment edges and wrap points
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd100, 8'd0,   8'd200);
      send_pixel(8'd0,   8'd255, 8'd127);
      send_pixel(8'd0,   8'd255, 8'd128);
      send_pixel(8'd42,  8'd200, 8'd90);
      send_pixel(8'd43,  8'd200, 8'd90);
      send_pixel(8'd127, 8'd200, 8'd160);
      send_pixel(8'd128, 8'd200, 8'd160);
      send_pixel(8'd169, 8'd150, 8'd60);
      send_pixel(8'd170, 8'd150, 8'd60);
      send_pixel(8'd171, 8'd150, 8'd60);
      send_pixel(8'd84,  8'd255, 8'd100);
      send_pixel(8'd85,  8'd255, 8'd100);
      send_pixel(8'd86,  8'd255, 8'd100);
      send_pixel(8'd255, 8'd1,   8'd1);
      send_pixel(8'd1,   8'd255, 8'd254);
      send_pixel(8'd212, 8'd128, 8'd255);
      send_pixel(8'd170, 8'd255, 8'd128);
      send_pixel(8'd255, 8'd255, 8'd127);
      send_pixel(8'd0,   8'd1,   8'd255);
      send_pixel(8'hAA,  8'h55,  8'hAA);
      drain_pipeline();

      write_swap(1'b0);
      send_random_pixels(RANDOM_PER_PHASE);
      drain_pipeline();

      sender_idle_pct   = 69;
      receiver_idle_pct = 30;
      write_swap(1'b1);
      send_random_pixels(RANDOM_PER_PHASE);
      drain_pipeline();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_swap(1'b0);
      // long stall on the rgb side while pixels keep coming, so the pipeline backs up
      hold_off_req = ~hold_off_req;
      send_random_pixels(RANDOM_PER_PHASE);
      drain_pipeline();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("checked %0d rgb words in %0d cycles: corner pixels, random pixels",
               words_checked, cycle_count);
      $display("under three idle mixes, both channel orders and a %0d-cycle receiver stall",
               HOLD_OFF_CYCLES);
      if (error_count == 0 && pending_words == 0)
         $display("PASS hsl_to_rgb_pixel");
      else
         $display("FAIL hsl_to_rgb_pixel");
      $finish;
   end

endmodule

FILE: files.f
design/hsl2rgb_pkg.sv
design/hsl_to_rgb_pixel.sv
tb/hsl_to_rgb_checker.sv
tb/tb_hsl_to_rgb_pixel.sv
